// ===== rtl/core/pixel_color_space_converter_assert.svh =====
`ifndef PIXEL_COLOR_SPACE_CONVERTER_ASSERT_SVH
`define PIXEL_COLOR_SPACE_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pcsc_pkg.sv =====
package pcsc_pkg;

    typedef enum logic [2:0] {
        MODE_BGR_YCC  = 3'd0,
        MODE_BGR_GRAY = 3'd1,
        MODE_RGB_YCC  = 3'd2,
        MODE_RGB_GRAY = 3'd3,
        MODE_YCC_BGR  = 3'd4
    } t_mode;

    localparam int unsigned MODE_W = 3;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned FWD_W  = 24;
    localparam int unsigned INV_W  = 20;
    localparam int unsigned INVP_W = 18;

    localparam logic [15:0] K_Y_R  = 16'd19595;
    localparam logic [15:0] K_Y_G  = 16'd38470;
    localparam logic [15:0] K_Y_B  = 16'd7471;
    localparam logic [15:0] K_ROUND = 16'd32767;
    localparam logic [15:0] K_CB_R = 16'd11059;
    localparam logic [15:0] K_CB_G = 16'd21709;
    localparam logic [15:0] K_CR_G = 16'd27439;
    localparam logic [15:0] K_CR_B = 16'd5329;
    localparam logic [FWD_W-1:0] K_CHROMA_BIAS = 24'd8388608;

    localparam logic signed [9:0] K_R_CR = 10'sd358;
    localparam logic signed [9:0] K_G_CR = 10'sd183;
    localparam logic signed [9:0] K_G_CB = 10'sd87;
    localparam logic signed [9:0] K_B_CB = 10'sd454;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage

// ===== rtl/core/pcsc_datapath.sv =====
module pcsc_datapath
    import pcsc_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [PIX_W-1:0]  i_chan0,
    input  logic [PIX_W-1:0]  i_chan1,
    input  logic [PIX_W-1:0]  i_chan2,
    output logic [PIX_W-1:0]  o_chan0,
    output logic [PIX_W-1:0]  o_chan1,
    output logic [PIX_W-1:0]  o_chan2
);

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [INV_W-1:0] s);
        logic signed [INV_W-9:0] q;
        q = INV_W'(s >>> 8) >= 0 ? (INV_W-8)'(s >>> 8) : (INV_W-8)'(s >>> 8);
        if (q < 0) begin
            return '0;
        end else if (q > 255) begin
            return 8'd255;
        end else begin
            return q[PIX_W-1:0];
        end
    endfunction

    // stage 1: products
    logic [MODE_W-1:0]        r_mode1;
    logic [PIX_W-1:0]         r_r1;
    logic [PIX_W-1:0]         r_b1;
    logic [PIX_W-1:0]         r_y1;
    logic [FWD_W-1:0]         r_py_r, r_py_g, r_py_b;
    logic [FWD_W-1:0]         r_pcb_r, r_pcb_g, r_pcr_g, r_pcr_b;
    logic signed [INVP_W-1:0] r_p_rcr, r_p_gcr, r_p_gcb, r_p_bcb;

    logic [PIX_W-1:0]        n_r, n_b;
    logic signed [PIX_W-1:0] n_cb, n_cr;

    always_comb begin
        if (i_mode == MODE_RGB_YCC || i_mode == MODE_RGB_GRAY) begin
            n_r = i_chan0;
            n_b = i_chan2;
        end else begin
            n_r = i_chan2;
            n_b = i_chan0;
        end
        n_cb = signed'({~i_chan1[PIX_W-1], i_chan1[PIX_W-2:0]});
        n_cr = signed'({~i_chan2[PIX_W-1], i_chan2[PIX_W-2:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_mode1 <= i_mode;
            r_r1    <= n_r;
            r_b1    <= n_b;
            r_y1    <= i_chan0;
            r_py_r  <= FWD_W'(n_r) * FWD_W'(K_Y_R);
            r_py_g  <= FWD_W'(i_chan1) * FWD_W'(K_Y_G);
            r_py_b  <= FWD_W'(n_b) * FWD_W'(K_Y_B);
            r_pcb_r <= FWD_W'(n_r) * FWD_W'(K_CB_R);
            r_pcb_g <= FWD_W'(i_chan1) * FWD_W'(K_CB_G);
            r_pcr_g <= FWD_W'(i_chan1) * FWD_W'(K_CR_G);
            r_pcr_b <= FWD_W'(n_b) * FWD_W'(K_CR_B);
            r_p_rcr <= INVP_W'(n_cr) * INVP_W'(K_R_CR);
            r_p_gcr <= INVP_W'(n_cr) * INVP_W'(K_G_CR);
            r_p_gcb <= INVP_W'(n_cb) * INVP_W'(K_G_CB);
            r_p_bcb <= INVP_W'(n_cb) * INVP_W'(K_B_CB);
        end
    end

    // stage 2: sums
    logic [MODE_W-1:0]       r_mode2;
    logic [PIX_W-1:0]        r_ylum2, r_cb2, r_cr2;
    logic signed [INV_W-1:0] r_sr2, r_sg2, r_sb2;

    logic [FWD_W-1:0]        n_ysum, n_cbsum, n_crsum;
    logic signed [INV_W-1:0] n_y256;

    always_comb begin
        n_ysum  = r_py_r + r_py_g + r_py_b + FWD_W'(K_ROUND);
        n_cbsum = FWD_W'({r_b1, 15'b0}) + FWD_W'(K_ROUND) + K_CHROMA_BIAS
                  - r_pcb_r - r_pcb_g;
        n_crsum = FWD_W'({r_r1, 15'b0}) + FWD_W'(K_ROUND) + K_CHROMA_BIAS
                  - r_pcr_g - r_pcr_b;
        n_y256  = signed'(INV_W'({r_y1, 8'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_mode2 <= r_mode1;
            r_ylum2 <= n_ysum[FWD_W-1:FWD_W-PIX_W];
            r_cb2   <= n_cbsum[FWD_W-1:FWD_W-PIX_W];
            r_cr2   <= n_crsum[FWD_W-1:FWD_W-PIX_W];
            r_sr2   <= n_y256 + INV_W'(r_p_rcr);
            r_sg2   <= n_y256 - INV_W'(r_p_gcr) - INV_W'(r_p_gcb);
            r_sb2   <= n_y256 + INV_W'(r_p_bcb);
        end
    end

    // stage 3: clamp and select
    logic [PIX_W-1:0] r_o0, r_o1, r_o2;
    logic [PIX_W-1:0] n_o0, n_o1, n_o2;

    always_comb begin
        unique case (r_mode2)
            MODE_BGR_YCC, MODE_RGB_YCC: begin
                n_o0 = r_ylum2;
                n_o1 = r_cb2;
                n_o2 = r_cr2;
            end
            MODE_BGR_GRAY, MODE_RGB_GRAY: begin
                n_o0 = r_ylum2;
                n_o1 = '0;
                n_o2 = '0;
            end
            MODE_YCC_BGR: begin
                n_o0 = clamp8(r_sb2);
                n_o1 = clamp8(r_sg2);
                n_o2 = clamp8(r_sr2);
            end
            default: begin
                n_o0 = '0;
                n_o1 = '0;
                n_o2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_o0 <= n_o0;
            r_o1 <= n_o1;
            r_o2 <= n_o2;
        end
    end

    assign o_chan0 = r_o0;
    assign o_chan1 = r_o1;
    assign o_chan2 = r_o2;

endmodule

// ===== rtl/core/pixel_color_space_converter.sv =====
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------
// input     | i_valid / o_stall   | i_in_chan0, i_in_chan1, i_in_chan2
// output    | o_valid / i_stall   | o_out_chan0, o_out_chan1, o_out_chan2
// config    | i_cfg_we            | i_cfg_data (conversion mode)
//
// One pixel per cycle while o_stall is low; each pixel passes through the product, sum and
// clamp/select register stages.
// Reset clears the stage valid bits and sets the mode to bgr-ycbcr.
// A stall holds the output register; earlier stages keep moving into empty
// slots, so o_stall rises only when all three stages are full.
`include "pixel_color_space_converter_assert.svh"

module pixel_color_space_converter
    import pcsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_in_chan0,
    input  logic [PIX_W-1:0]  i_in_chan1,
    input  logic [PIX_W-1:0]  i_in_chan2,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_out_chan0,
    output logic [PIX_W-1:0]  o_out_chan1,
    output logic [PIX_W-1:0]  o_out_chan2
);

    logic [MODE_W-1:0] r_mode;
    logic [3:1]        r_vld;
    t_pipe_ctl         w_ctl;

    always_comb begin
        w_ctl.en3 = !r_vld[3] || !i_stall;
        w_ctl.en2 = !r_vld[2] || w_ctl.en3;
        w_ctl.en1 = !r_vld[1] || w_ctl.en2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BGR_YCC;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_ctl.en1) begin
                r_vld[1] <= i_valid;
            end
            if (w_ctl.en2) begin
                r_vld[2] <= r_vld[1];
            end
            if (w_ctl.en3) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    pcsc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_mode  (r_mode),
        .i_chan0 (i_in_chan0),
        .i_chan1 (i_in_chan1),
        .i_chan2 (i_in_chan2),
        .o_chan0 (o_out_chan0),
        .o_chan1 (o_out_chan1),
        .o_chan2 (o_out_chan2)
    );

    assign o_stall = !w_ctl.en1;
    assign o_valid = r_vld[3];

    `PCSC_ASSERT_NOW(a_stall_only_when_full, o_stall, r_vld == 3'b111,
        "input stalled while a pipeline stage is empty")
    `PCSC_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_vld[1],
        "accepted transaction did not enter stage one")
    `PCSC_ASSERT_NEXT(a_bubble_drains, r_vld[3] && !i_stall && !r_vld[2], !o_valid,
        "output valid without a transaction behind it")

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import pcsc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_UNITS = 1_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS = 45;
    localparam int HOLD_START = 150;
    localparam int HOLD_CYCLES = 60;

    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int LUMA_R = 19595;
    localparam int LUMA_G = 38470;
    localparam int LUMA_B = 7471;
    localparam int ROUND_HALF = 32767;
    localparam int CB_R = 11059;
    localparam int CB_G = 21709;
    localparam int CR_G = 27439;
    localparam int CR_B = 5329;
    localparam int CHROMA_UNIT = 32768;
    localparam int CHROMA_BIAS = 128 << 16;
    localparam int R_FROM_CR = 358;
    localparam int G_FROM_CR = 183;
    localparam int G_FROM_CB = 87;
    localparam int B_FROM_CB = 454;

    typedef struct packed {
        logic [PIX_W-1:0] c0;
        logic [PIX_W-1:0] c1;
        logic [PIX_W-1:0] c2;
    } t_pixel;

    typedef struct {
        logic              set_mode;
        logic [MODE_W-1:0] mode;
        t_pixel            px;
    } t_stim;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [MODE_W-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_in_chan0 = '0;
    logic [PIX_W-1:0]  i_in_chan1 = '0;
    logic [PIX_W-1:0]  i_in_chan2 = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [PIX_W-1:0]  o_out_chan0;
    logic [PIX_W-1:0]  o_out_chan1;
    logic [PIX_W-1:0]  o_out_chan2;

    t_stim  stim_q[$];
    t_pixel exp_q[$];

    int   gap_left = 0;
    int   stall_left = 0;
    int   n_sent = 0;
    int   n_recv = 0;
    int   n_items = 0;
    int   n_cfg = 0;
    int   n_err = 0;
    int   n_held = 0;
    int   cycle_cnt = 0;
    logic long_hold = 1'b0;

    pixel_color_space_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_chan0  (i_in_chan0),
        .i_in_chan1  (i_in_chan1),
        .i_in_chan2  (i_in_chan2),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_chan0 (o_out_chan0),
        .o_out_chan1 (o_out_chan1),
        .o_out_chan2 (o_out_chan2)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int clamp_byte(input int v);
        if (v < 0) begin
            return 0;
        end else if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    function automatic t_pixel predict(input logic [MODE_W-1:0] mode, input t_pixel px);
        int c0, c1, c2;
        int r, g, b;
        int y, cb, cr;
        int cbv, crv;
        int rr, gg, bb;
        t_pixel res;
        c0 = int'(px.c0);
        c1 = int'(px.c1);
        c2 = int'(px.c2);
        unique case (mode)
            MODE_BGR_YCC, MODE_BGR_GRAY: begin
                r = c2;
                b = c0;
            end
            MODE_RGB_YCC, MODE_RGB_GRAY: begin
                r = c0;
                b = c2;
            end
            default: begin
                r = 0;
                b = 0;
            end
        endcase
        g   = c1;
        y   = (r * LUMA_R + g * LUMA_G + b * LUMA_B + ROUND_HALF) >>> 16;
        cb  = (b * CHROMA_UNIT - r * CB_R - g * CB_G + ROUND_HALF + CHROMA_BIAS) >>> 16;
        cr  = (r * CHROMA_UNIT - g * CR_G - b * CR_B + ROUND_HALF + CHROMA_BIAS) >>> 16;
        cbv = c1 - 128;
        crv = c2 - 128;
        rr  = (256 * c0 + R_FROM_CR * crv) >>> 8;
        gg  = (256 * c0 - G_FROM_CR * crv - G_FROM_CB * cbv) >>> 8;
        bb  = (256 * c0 + B_FROM_CB * cbv) >>> 8;
        res = '0;
        unique case (mode)
            MODE_BGR_YCC, MODE_RGB_YCC: begin
                res.c0 = PIX_W'(y);
                res.c1 = PIX_W'(clamp_byte(cb));
                res.c2 = PIX_W'(clamp_byte(cr));
            end
            MODE_BGR_GRAY, MODE_RGB_GRAY: begin
                res.c0 = PIX_W'(y);
            end
            MODE_YCC_BGR: begin
                res.c0 = PIX_W'(clamp_byte(bb));
                res.c1 = PIX_W'(clamp_byte(gg));
                res.c2 = PIX_W'(clamp_byte(rr));
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    function automatic logic [MODE_W-1:0] phase_mode(input int p);
        unique case (p)
            0:       return MODE_BGR_YCC;
            1:       return MODE_BGR_GRAY;
            2:       return MODE_RGB_YCC;
            3:       return MODE_RGB_GRAY;
            4:       return MODE_YCC_BGR;
            5:       return MODE_SPARE_5;
            6:       return MODE_YCC_BGR;
            7:       return MODE_SPARE_6;
            8:       return MODE_RGB_YCC;
            9:       return MODE_SPARE_7;
            10:      return MODE_YCC_BGR;
            default: return MODE_BGR_YCC;
        endcase
    endfunction

    function automatic t_pixel make_pixel(input int k);
        t_pixel px;
        unique case (k)
            0: begin
                px.c0 = 8'd0;
                px.c1 = 8'd0;
                px.c2 = 8'd0;
            end
            1: begin
                px.c0 = 8'd255;
                px.c1 = 8'd255;
                px.c2 = 8'd255;
            end
            2: begin
                px.c0 = 8'd0;
                px.c1 = 8'd255;
                px.c2 = 8'd0;
            end
            3: begin
                px.c0 = 8'd255;
                px.c1 = 8'd0;
                px.c2 = 8'd255;
            end
            default: begin
                px.c0 = PIX_W'($urandom_range(0, 255));
                px.c1 = PIX_W'($urandom_range(0, 255));
                px.c2 = PIX_W'($urandom_range(0, 255));
            end
        endcase
        return px;
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end else if (pick < 95) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(10, 30));
    endfunction

    always @(posedge i_clk) begin : drive
        t_stim s;
        logic  accepted;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left <= 0;
            n_sent   <= 0;
            n_cfg    <= 0;
        end else begin
            accepted = i_valid && !o_stall;
            if (accepted) begin
                n_sent <= n_sent + 1;
            end
            if (i_valid && !accepted) begin
                i_cfg_we <= 1'b0;
            end else if (gap_left > 0) begin
                i_valid  <= 1'b0;
                i_cfg_we <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (stim_q.size() == 0) begin
                i_valid  <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (stim_q[0].set_mode) begin
                i_valid <= 1'b0;
                if (!accepted && n_sent == n_recv) begin
                    s = stim_q.pop_front();
                    i_cfg_we   <= 1'b1;
                    i_cfg_data <= s.mode;
                    n_cfg      <= n_cfg + 1;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end else begin
                s = stim_q.pop_front();
                i_valid    <= 1'b1;
                i_cfg_we   <= 1'b0;
                i_in_chan0 <= s.px.c0;
                i_in_chan1 <= s.px.c1;
                i_in_chan2 <= s.px.c2;
                gap_left   <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : pressure
        if (!i_rst_n) begin
            cycle_cnt <= 0;
            long_hold <= 1'b0;
            n_held    <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            long_hold <= (cycle_cnt >= HOLD_START) && (cycle_cnt < HOLD_START + HOLD_CYCLES);
            if (i_valid && o_stall) begin
                n_held <= n_held + 1;
            end
        end
    end

    always @(posedge i_clk) begin : receive
        t_pixel      exp_px;
        int unsigned pick;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
            n_recv     <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_recv <= n_recv + 1;
                if (exp_q.size() == 0) begin
                    $error("unexpected output transaction");
                    n_err = n_err + 1;
                end else begin
                    exp_px = exp_q.pop_front();
                    if (o_out_chan0 !== exp_px.c0) begin
                        $error("out_chan0 expected %0d actual %0d", exp_px.c0, o_out_chan0);
                        n_err = n_err + 1;
                    end
                    if (o_out_chan1 !== exp_px.c1) begin
                        $error("out_chan1 expected %0d actual %0d", exp_px.c1, o_out_chan1);
                        n_err = n_err + 1;
                    end
                    if (o_out_chan2 !== exp_px.c2) begin
                        $error("out_chan2 expected %0d actual %0d", exp_px.c2, o_out_chan2);
                        n_err = n_err + 1;
                    end
                end
            end
            if (long_hold) begin
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    i_stall <= 1'b0;
                end else if (pick < 97) begin
                    i_stall    <= 1'b1;
                    stall_left <= int'($urandom_range(0, 2));
                end else begin
                    i_stall    <= 1'b1;
                    stall_left <= int'($urandom_range(10, 25));
                end
            end
        end
    end

    initial begin : stimulus
        t_stim             s;
        logic [MODE_W-1:0] mode;
        mode = MODE_BGR_YCC;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p != 0) begin
                mode       = phase_mode(p);
                s.set_mode = 1'b1;
                s.mode     = mode;
                s.px       = '0;
                stim_q.push_back(s);
            end
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                s.set_mode = 1'b0;
                s.mode     = mode;
                s.px       = make_pixel(k);
                stim_q.push_back(s);
                exp_q.push_back(predict(mode, s.px));
                n_items = n_items + 1;
            end
        end
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_recv == n_items);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("converted %0d pixels across %0d mode changes, all five modes and spare codes",
                 n_recv, n_cfg);
        $display("input held off for %0d cycles while the output side was blocked", n_held);
        if (n_err == 0 && exp_q.size() == 0 && stim_q.size() == 0 && n_sent == n_items) begin
            $display("pixel_color_space_converter test passed");
        end else begin
            $display("pixel_color_space_converter test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_UNITS);
        $error("run did not complete in time");
        $display("pixel_color_space_converter test failed");
        $finish;
    end

endmodule
